@@ hw/rtl/sfegc_pkg.sv @@
// shared types, constants and helpers for the scope front-end gain control
package sfegc_pkg;

    localparam int BUTTON_COUNT = 6;
    localparam int DEB_W        = 16;
    localparam int CFG_GAIN_W   = 5;
    localparam int OUT_GAIN_W   = 5;
    localparam int GAIN_W_MAX   = 8;
    localparam int TRIG_W       = 8;
    localparam int ATT_OH_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;

    // button bit positions
    localparam int BTN_ZOOM_IN   = 0;
    localparam int BTN_ZOOM_OUT  = 3;
    localparam int BTN_TRIG_DOWN = 4;
    localparam int BTN_TRIG_UP   = 5;

    localparam logic [DEB_W-1:0]  DEB_RESET      = 16'd10000;
    localparam logic [CFG_GAIN_W-1:0] MIN_RESET  = 5'd0;
    localparam logic [CFG_GAIN_W-1:0] MAX_RESET  = 5'd31;
    localparam logic [TRIG_W-1:0] TRIG_RESET     = 8'd128;

    typedef enum logic [1:0] {
        ATT_1_1 = 2'd0,
        ATT_2_1 = 2'd1,
        ATT_5_1 = 2'd2
    } att_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_MIN_GAIN = 2'd1,
        REG_MAX_GAIN = 2'd2
    } cfg_reg_t;

    // debounce timer status for the current word
    typedef struct packed {
        logic act;
        logic busy;
    } dbn_status_t;

    // change strobes for the current word
    typedef struct packed {
        logic gain_strobe;
        logic att_strobe;
        logic trig_changed;
    } act_flags_t;

    function automatic logic [ATT_OH_W-1:0] att_onehot(input att_t a);
        logic [ATT_OH_W-1:0] r;
        begin
            case (a)
                ATT_1_1: r = 3'b001;
                ATT_2_1: r = 3'b010;
                ATT_5_1: r = 3'b100;
                default: r = 3'b000;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/sfegc_debounce.sv @@
// edge detect and debounce wait timer
module sfegc_debounce (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic [sfegc_pkg::BUTTON_COUNT-1:0]      buttons,
    input  logic [sfegc_pkg::DEB_W-1:0]             debounce_ticks,
    output sfegc_pkg::dbn_status_t                  status
);

    logic [sfegc_pkg::BUTTON_COUNT-1:0] last_reg, last_next;
    logic [sfegc_pkg::DEB_W-1:0]        count_reg, count_next;
    logic                               waiting_reg, waiting_next;
    logic                               pend_reg, pend_next;
    logic                               edge_seen;
    logic                               pend_any;
    logic                               act;

    assign edge_seen = |(buttons & ~last_reg);
    assign pend_any  = pend_reg | edge_seen;

    always_comb begin
        last_next    = buttons;
        count_next   = count_reg;
        waiting_next = waiting_reg;
        pend_next    = pend_reg;
        act          = 1'b0;
        if (!waiting_reg) begin
            if (edge_seen) begin
                waiting_next = 1'b1;
                count_next   = '0;
                pend_next    = 1'b0;
            end
        end else begin
            pend_next = pend_any;
            if (count_reg >= debounce_ticks) begin
                act          = 1'b1;
                waiting_next = 1'b0;
                // edges during the wait restart it right away
                if (pend_any) begin
                    waiting_next = 1'b1;
                    count_next   = '0;
                    pend_next    = 1'b0;
                end
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= '0;
            count_reg   <= '0;
            waiting_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (en) begin
            last_reg    <= last_next;
            count_reg   <= count_next;
            waiting_reg <= waiting_next;
            pend_reg    <= pend_next;
        end
    end

    assign status.act  = act;
    assign status.busy = waiting_next;

endmodule

@@ hw/rtl/sfegc_actions.sv @@
// gain, attenuator and trigger level state with the button actions
module sfegc_actions #(
    parameter int GAIN_BITS = 5
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    act,
    input  logic [sfegc_pkg::BUTTON_COUNT-1:0]      buttons,
    input  logic [sfegc_pkg::CFG_GAIN_W-1:0]        vga_min_gain,
    input  logic [sfegc_pkg::CFG_GAIN_W-1:0]        vga_max_gain,
    output logic [GAIN_BITS-1:0]                    gain,
    output sfegc_pkg::att_t                         atten,
    output logic [sfegc_pkg::TRIG_W-1:0]            trig_level,
    output logic [sfegc_pkg::TRIG_W-1:0]            trig_before,
    output sfegc_pkg::act_flags_t                   flags
);

    localparam logic [GAIN_BITS-1:0] GAIN_TOP = {GAIN_BITS{1'b1}};

    logic [GAIN_BITS-1:0]         gain_reg, gain_next, gain_mid;
    sfegc_pkg::att_t              att_reg, att_next, att_mid;
    logic [sfegc_pkg::TRIG_W-1:0] trig_reg, trig_next, trig_mid;
    logic [sfegc_pkg::TRIG_W-1:0] old_reg, old_next;
    logic [sfegc_pkg::GAIN_W_MAX-1:0] gain_mid_w, gain_cur_w, min_w, max_w;
    logic gl, al, tc;
    logic zin, zout, tdn, tup;

    assign zin  = act & buttons[sfegc_pkg::BTN_ZOOM_IN];
    assign zout = act & buttons[sfegc_pkg::BTN_ZOOM_OUT];
    assign tdn  = act & buttons[sfegc_pkg::BTN_TRIG_DOWN];
    assign tup  = act & buttons[sfegc_pkg::BTN_TRIG_UP];

    assign gain_cur_w = sfegc_pkg::GAIN_W_MAX'(gain_reg);
    assign gain_mid_w = sfegc_pkg::GAIN_W_MAX'(gain_mid);
    assign min_w      = sfegc_pkg::GAIN_W_MAX'(vga_min_gain);
    assign max_w      = sfegc_pkg::GAIN_W_MAX'(vga_max_gain);

    // zoom in, then zoom out on what zoom in left
    always_comb begin
        gain_mid = gain_reg;
        att_mid  = att_reg;
        gl       = 1'b0;
        al       = 1'b0;
        if (zin) begin
            case (att_reg)
                sfegc_pkg::ATT_1_1: begin
                    if (gain_cur_w < max_w && gain_reg != GAIN_TOP) begin
                        gain_mid = gain_reg + 1'b1;
                        gl       = 1'b1;
                    end
                end
                sfegc_pkg::ATT_2_1: begin
                    att_mid = sfegc_pkg::ATT_1_1;
                    al      = 1'b1;
                end
                default: begin
                    att_mid = sfegc_pkg::ATT_2_1;
                    al      = 1'b1;
                end
            endcase
        end
        gain_next = gain_mid;
        att_next  = att_mid;
        if (zout) begin
            if (gain_mid_w == min_w) begin
                case (att_mid)
                    sfegc_pkg::ATT_1_1: begin
                        att_next = sfegc_pkg::ATT_2_1;
                        al       = 1'b1;
                    end
                    sfegc_pkg::ATT_2_1: begin
                        att_next = sfegc_pkg::ATT_5_1;
                        al       = 1'b1;
                    end
                    default: att_next = att_mid;
                endcase
            end else if (gain_mid_w > min_w) begin
                gain_next = gain_mid - 1'b1;
                gl        = 1'b1;
            end
        end
    end

    // trigger down, then trigger up
    always_comb begin
        trig_mid  = trig_reg;
        old_next  = old_reg;
        if (tdn) begin
            old_next = trig_reg;
            trig_mid = trig_reg - 1'b1;
        end
        trig_next = trig_mid;
        if (tup) begin
            old_next  = trig_mid;
            trig_next = trig_mid + 1'b1;
        end
        tc = tdn | tup;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
            att_reg  <= sfegc_pkg::ATT_1_1;
            trig_reg <= sfegc_pkg::TRIG_RESET;
            old_reg  <= '0;
        end else if (en) begin
            gain_reg <= gain_next;
            att_reg  <= att_next;
            trig_reg <= trig_next;
            old_reg  <= old_next;
        end
    end

    assign gain               = gain_next;
    assign atten              = att_next;
    assign trig_level         = trig_next;
    assign trig_before        = old_next;
    assign flags.gain_strobe  = gl;
    assign flags.att_strobe   = al;
    assign flags.trig_changed = tc;

endmodule

@@ hw/rtl/scope_front_end_gain_control_unit.sv @@
// top level: config registers, debounce, actions and the result register
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[5:0] buttons
//  m_        out  m_tvalid/m_tready    m_tdata[27:0] status word
//  cfg_      in   cfg_wr_en            cfg_index, cfg_data
//
// one word in per clock while s_tready is high, result registered in the cycle after acceptance
// the only storage between the channels is a single result register
// s_tready drops only while that register holds a word m_tready has not taken
// all control state resets to its defaults on a synchronous low aresetn, no clearing pass
module scope_front_end_gain_control_unit #(
    parameter int GAIN_BITS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] buttons, [7:6] zero
    input  logic [sfegc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [4:0] vga_gain, [5] gain strobe, [8:6] atten_enable, [9] atten strobe,
    // [17:10] trigger_level, [25:18] trigger_before, [26] trigger_changed,
    // [27] debounce_busy, [31:28] zero
    output logic [sfegc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [sfegc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfegc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [sfegc_pkg::DEB_W-1:0]      deb_reg;
    logic [sfegc_pkg::CFG_GAIN_W-1:0] min_reg;
    logic [sfegc_pkg::CFG_GAIN_W-1:0] max_reg;

    logic                              in_fire;
    logic [sfegc_pkg::BUTTON_COUNT-1:0] buttons;
    sfegc_pkg::dbn_status_t            dbn;
    sfegc_pkg::act_flags_t             flags;
    logic [GAIN_BITS-1:0]              gain;
    sfegc_pkg::att_t                   atten;
    logic [sfegc_pkg::TRIG_W-1:0]      trig_level;
    logic [sfegc_pkg::TRIG_W-1:0]      trig_before;
    logic [sfegc_pkg::GAIN_W_MAX-1:0]  gain_w;
    logic [sfegc_pkg::M_TDATA_W-1:0]   word_next;
    logic [sfegc_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic                              m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= sfegc_pkg::DEB_RESET;
            min_reg <= sfegc_pkg::MIN_RESET;
            max_reg <= sfegc_pkg::MAX_RESET;
        end else if (cfg_wr_en) begin
            case (sfegc_pkg::cfg_reg_t'(cfg_index))
                sfegc_pkg::REG_DEBOUNCE: deb_reg <= cfg_data;
                sfegc_pkg::REG_MIN_GAIN: min_reg <= cfg_data[sfegc_pkg::CFG_GAIN_W-1:0];
                sfegc_pkg::REG_MAX_GAIN: max_reg <= cfg_data[sfegc_pkg::CFG_GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign buttons  = s_tdata[sfegc_pkg::BUTTON_COUNT-1:0];

    sfegc_debounce u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (in_fire),
        .buttons        (buttons),
        .debounce_ticks (deb_reg),
        .status         (dbn)
    );

    sfegc_actions #(
        .GAIN_BITS (GAIN_BITS)
    ) u_actions (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (in_fire),
        .act          (dbn.act),
        .buttons      (buttons),
        .vga_min_gain (min_reg),
        .vga_max_gain (max_reg),
        .gain         (gain),
        .atten        (atten),
        .trig_level   (trig_level),
        .trig_before  (trig_before),
        .flags        (flags)
    );

    assign gain_w    = sfegc_pkg::GAIN_W_MAX'(gain);
    assign word_next = {4'b0000,
                        dbn.busy,
                        flags.trig_changed,
                        trig_before,
                        trig_level,
                        flags.att_strobe,
                        sfegc_pkg::att_onehot(atten),
                        flags.gain_strobe,
                        gain_w[sfegc_pkg::OUT_GAIN_W-1:0]};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (in_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= word_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // attenuator select is always exactly one of the three taps
    a_atten_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[8:6]))
        else $error("attenuator select not one-hot");

    // a trigger step always leaves the old level different from the new one
    a_trig_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26] |-> (m_tdata[17:10] != m_tdata[25:18]))
        else $error("trigger step left level equal to previous level");

    // an accepted word always shows up in the result register next cycle
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("accepted word produced no result");

    // input stalls only behind a result that is held back
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

endmodule
